FILE: hw/rtl/upsc_pkg.sv
package upsc_pkg;

  localparam int PIXEL_BITS = 32;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  localparam logic [1:0] SCALE_MODE_RST = 2'd2;
  localparam logic [1:0] MODE_3X        = 2'd3;

  localparam int EDGE_TOP   = 0;
  localparam int EDGE_BOT   = 1;
  localparam int EDGE_LEFT  = 2;
  localparam int EDGE_RIGHT = 3;

  // Full 3x3 neighborhood after edge substitution
  typedef struct packed {
    logic mode3;
    pix_t a;
    pix_t b;
    pix_t c;
    pix_t d;
    pix_t e;
    pix_t f;
    pix_t g;
    pix_t h;
    pix_t i;
  } nbr_t;

  // Equality terms plus the pixels the selectors still need
  typedef struct packed {
    logic mode3;
    logic active;
    logic db;
    logic bf;
    logic dh;
    logic hf;
    logic ea;
    logic ec;
    logic eg;
    logic ei;
    pix_t b;
    pix_t d;
    pix_t e;
    pix_t f;
    pix_t h;
  } cmp_t;

  typedef struct packed {
    pix_t r0c0;
    pix_t r0c1;
    pix_t r0c2;
    pix_t r1c0;
    pix_t r1c1;
    pix_t r1c2;
    pix_t r2c0;
    pix_t r2c1;
    pix_t r2c2;
  } blk_t;

endpackage

FILE: hw/rtl/upsc_edge.sv
module upsc_edge import upsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  logic       mode3,
  input  pix_t       center,
  input  pix_t       up,
  input  pix_t       down,
  input  pix_t       left,
  input  pix_t       right,
  input  pix_t       up_left,
  input  pix_t       up_right,
  input  pix_t       down_left,
  input  pix_t       down_right,
  input  logic [3:0] edge_flags,
  output logic       valid_r,
  output nbr_t       nbr_r,
  input  logic       dn_ready
);

  logic top, bot, lft, rgt;
  nbr_t nbr_nxt;

  assign top = edge_flags[EDGE_TOP];
  assign bot = edge_flags[EDGE_BOT];
  assign lft = edge_flags[EDGE_LEFT];
  assign rgt = edge_flags[EDGE_RIGHT];

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    nbr_nxt.mode3 = mode3;
    nbr_nxt.e = center;
    nbr_nxt.b = top ? center : up;
    nbr_nxt.h = bot ? center : down;
    nbr_nxt.d = lft ? center : left;
    nbr_nxt.f = rgt ? center : right;
    // diagonal: center if both sides gone, the surviving orthogonal if one is, else the diagonal
    nbr_nxt.a = (top && lft) ? center : top ? nbr_nxt.d : lft ? nbr_nxt.b : up_left;
    nbr_nxt.c = (top && rgt) ? center : top ? nbr_nxt.f : rgt ? nbr_nxt.b : up_right;
    nbr_nxt.g = (bot && lft) ? center : bot ? nbr_nxt.d : lft ? nbr_nxt.h : down_left;
    nbr_nxt.i = (bot && rgt) ? center : bot ? nbr_nxt.f : rgt ? nbr_nxt.h : down_right;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      nbr_r <= nbr_nxt;
    end
  end

endmodule

FILE: hw/rtl/upsc_cmp.sv
module upsc_cmp import upsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  nbr_t nbr,
  output logic valid_r,
  output cmp_t cmp_r,
  input  logic dn_ready
);

  cmp_t cmp_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    cmp_nxt.mode3  = nbr.mode3;
    cmp_nxt.active = (nbr.b != nbr.h) && (nbr.d != nbr.f);
    cmp_nxt.db     = nbr.d == nbr.b;
    cmp_nxt.bf     = nbr.b == nbr.f;
    cmp_nxt.dh     = nbr.d == nbr.h;
    cmp_nxt.hf     = nbr.h == nbr.f;
    cmp_nxt.ea     = nbr.e == nbr.a;
    cmp_nxt.ec     = nbr.e == nbr.c;
    cmp_nxt.eg     = nbr.e == nbr.g;
    cmp_nxt.ei     = nbr.e == nbr.i;
    cmp_nxt.b      = nbr.b;
    cmp_nxt.d      = nbr.d;
    cmp_nxt.e      = nbr.e;
    cmp_nxt.f      = nbr.f;
    cmp_nxt.h      = nbr.h;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      cmp_r <= cmp_nxt;
    end
  end

endmodule

FILE: hw/rtl/upsc_sel.sv
module upsc_sel import upsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  cmp_t cmp,
  output logic valid_r,
  output blk_t blk_r,
  input  logic dn_ready
);

  blk_t blk_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    blk_nxt = '0;
    if (!cmp.active) begin
      blk_nxt.r0c0 = cmp.e;
      blk_nxt.r0c1 = cmp.e;
      blk_nxt.r1c0 = cmp.e;
      blk_nxt.r1c1 = cmp.e;
      if (cmp.mode3) begin
        blk_nxt.r0c2 = cmp.e;
        blk_nxt.r1c2 = cmp.e;
        blk_nxt.r2c0 = cmp.e;
        blk_nxt.r2c1 = cmp.e;
        blk_nxt.r2c2 = cmp.e;
      end
    end else if (cmp.mode3) begin
      blk_nxt.r0c0 = cmp.db ? cmp.d : cmp.e;
      blk_nxt.r0c1 = ((cmp.db && !cmp.ec) || (cmp.bf && !cmp.ea)) ? cmp.b : cmp.e;
      blk_nxt.r0c2 = cmp.bf ? cmp.f : cmp.e;
      blk_nxt.r1c0 = ((cmp.db && !cmp.eg) || (cmp.dh && !cmp.ea)) ? cmp.d : cmp.e;
      blk_nxt.r1c1 = cmp.e;
      blk_nxt.r1c2 = ((cmp.bf && !cmp.ei) || (cmp.hf && !cmp.ec)) ? cmp.f : cmp.e;
      blk_nxt.r2c0 = cmp.dh ? cmp.d : cmp.e;
      blk_nxt.r2c1 = ((cmp.dh && !cmp.ei) || (cmp.hf && !cmp.eg)) ? cmp.h : cmp.e;
      blk_nxt.r2c2 = cmp.hf ? cmp.f : cmp.e;
    end else begin
      blk_nxt.r0c0 = cmp.db ? cmp.d : cmp.e;
      blk_nxt.r0c1 = cmp.bf ? cmp.f : cmp.e;
      blk_nxt.r1c0 = cmp.dh ? cmp.d : cmp.e;
      blk_nxt.r1c1 = cmp.hf ? cmp.f : cmp.e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      blk_r <= blk_nxt;
    end
  end

endmodule

FILE: hw/rtl/scale2x_scale3x_upscaler_top.sv
// Scale2x / Scale3x pixel-art upscaler.
// Input channel (in_*): one source pixel with its eight neighbors and the
// four image-edge flags per transfer; qualified by in_valid, held off by
// in_stall. Output channel (out_*): the 3x3 enlarged block per transfer,
// qualified by out_valid, held off by out_stall. In 2x mode only the
// top-left 2x2 carries pixels, the other five positions are zero.
// Configuration: cfg_wr_en writes cfg_wr_data into the scale mode
// register (3 = Scale3x, anything else = Scale2x). Change it only while
// nothing is in flight; the mode is sampled per item at the first stage.
// Pipeline: edge substitution, equality compares, output select, each
// ending in a register; throughput is one transfer per cycle with no
// stall.
// Stall: each stage holds its item while the next one is full and
// stalled, so a stalled output keeps its payload and bubbles are squeezed
// out; in_stall rises only once all three stages are occupied.
// Reset (rst_n low, synchronous) empties the pipeline and sets the mode
// to Scale2x.
module scale2x_scale3x_upscaler_top import upsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  pix_t       in_center,
  input  pix_t       in_up,
  input  pix_t       in_down,
  input  pix_t       in_left,
  input  pix_t       in_right,
  input  pix_t       in_up_left,
  input  pix_t       in_up_right,
  input  pix_t       in_down_left,
  input  pix_t       in_down_right,
  input  logic [3:0] in_edge_flags,
  output logic       out_valid,
  input  logic       out_stall,
  output pix_t       out_r0c0,
  output pix_t       out_r0c1,
  output pix_t       out_r0c2,
  output pix_t       out_r1c0,
  output pix_t       out_r1c1,
  output pix_t       out_r1c2,
  output pix_t       out_r2c0,
  output pix_t       out_r2c1,
  output pix_t       out_r2c2
);

  logic [1:0] scale_mode_r;

  logic s1_ready, s1_valid;
  logic s2_ready, s2_valid;
  logic s3_ready;
  nbr_t s1_nbr;
  cmp_t s2_cmp;
  blk_t s3_blk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r <= SCALE_MODE_RST;
    end else if (cfg_wr_en) begin
      scale_mode_r <= cfg_wr_data;
    end
  end

  assign in_stall = !s1_ready;

  // stage 1: replace missing neighbors at image edges
  upsc_edge u_edge (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (s1_ready),
    .mode3      (scale_mode_r == MODE_3X),
    .center     (in_center),
    .up         (in_up),
    .down       (in_down),
    .left       (in_left),
    .right      (in_right),
    .up_left    (in_up_left),
    .up_right   (in_up_right),
    .down_left  (in_down_left),
    .down_right (in_down_right),
    .edge_flags (in_edge_flags),
    .valid_r    (s1_valid),
    .nbr_r      (s1_nbr),
    .dn_ready   (s2_ready)
  );

  // stage 2: wide equality compares, reduced to single bits
  upsc_cmp u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .nbr      (s1_nbr),
    .valid_r  (s2_valid),
    .cmp_r    (s2_cmp),
    .dn_ready (s3_ready)
  );

  // stage 3: per-position select, doubles as the output register
  upsc_sel u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s3_ready),
    .cmp      (s2_cmp),
    .valid_r  (out_valid),
    .blk_r    (s3_blk),
    .dn_ready (!out_stall)
  );

  assign out_r0c0 = s3_blk.r0c0;
  assign out_r0c1 = s3_blk.r0c1;
  assign out_r0c2 = s3_blk.r0c2;
  assign out_r1c0 = s3_blk.r1c0;
  assign out_r1c1 = s3_blk.r1c1;
  assign out_r1c2 = s3_blk.r1c2;
  assign out_r2c0 = s3_blk.r2c0;
  assign out_r2c1 = s3_blk.r2c1;
  assign out_r2c2 = s3_blk.r2c2;

endmodule
